### rtl/tkh_pkg.sv
package tkh_pkg;

    // One heap slot: document id and Q16.16 score
    typedef struct packed {
        logic        [31:0] id;
        logic signed [31:0] score;
    } t_entry;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_CLEAR  = 3'd0;
    localparam t_cmd CMD_PUSH   = 3'd1;
    localparam t_cmd CMD_POP    = 3'd2;
    localparam t_cmd CMD_SET    = 3'd3;
    localparam t_cmd CMD_ADD    = 3'd4;
    localparam t_cmd CMD_REMOVE = 3'd5;

    localparam logic        [31:0] NO_ID     = 32'hFFFF_FFFF;
    localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

    localparam logic [10:0] CAP_RESET = 11'd1024;
    localparam logic        REG_CAPACITY = 1'b0;

endpackage

### rtl/topk_min_heap_top.sv
// Bounded binary min-heap keeping the top-k (id, score) pairs, one command per
// transaction. All slots live in one RAM with a registered read, so the
// single read port sets the time: clear and unknown commands go straight to
// the result; push into a heap that is not full reads and writes one parent
// per level climbed; push into a full heap, pop, set, add and remove sift down,
// reading both children and writing one slot per level; set, add and remove
// first scan slots from the root at one slot per cycle, so their time grows
// with the fill count. A new command is taken while the previous result waits
// in the output register.
module topk_min_heap_top #(
    parameter int CAPACITY = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s_axis: tdata = doc_id[31:0], score_in[63:32]; tuser = cmd[2:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    // m_axis: tdata = doc_out[31:0], score_out[63:32], count[74:64],
    //         threshold[106:75], zero[111:107]; tuser = hit[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tkh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PU_RD    = 4'd1;
    localparam logic [3:0] S_PU_CMP   = 4'd2;
    localparam logic [3:0] S_ROOT_RD  = 4'd3;
    localparam logic [3:0] S_ROOT_GET = 4'd4;
    localparam logic [3:0] S_POP_LAST = 4'd5;
    localparam logic [3:0] S_SRCH     = 4'd6;
    localparam logic [3:0] S_RM_LAST  = 4'd7;
    localparam logic [3:0] S_SD_L     = 4'd8;
    localparam logic [3:0] S_SD_R     = 4'd9;
    localparam logic [3:0] S_SD_CMP   = 4'd10;
    localparam logic [3:0] S_TH_RD    = 4'd11;
    localparam logic [3:0] S_TH_GET   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]          r_state;
    logic [10:0]         r_capacity;
    logic [CW-1:0]       r_fill;
    logic signed [31:0]  r_thr;
    t_cmd                r_cmd;
    logic [31:0]         r_id;
    logic signed [31:0]  r_sc;
    t_entry              r_v;
    t_entry              r_lc;
    logic                r_rv;
    logic                r_thn;
    logic [IW-1:0]       r_t;
    logic [IW-1:0]       r_p;
    logic [IW-1:0]       r_q;
    logic [IW-1:0]       r_si;
    logic [IW-1:0]       r_sp;
    logic                r_sv;
    logic [31:0]         r_dout;
    logic signed [31:0]  r_sout;
    logic                r_hit;
    logic                r_ovalid;
    logic [31:0]         r_o_doc;
    logic signed [31:0]  r_o_score;
    logic                r_o_hit;
    logic [10:0]         r_o_count;
    logic signed [31:0]  r_o_thr;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    t_entry              rdata;
    logic [63:0]         rdata_raw;

    logic [31:0]         cap32;
    logic [IW-1:0]       cap_i;
    logic [IW-1:0]       fill_i;
    logic [IW-1:0]       last_i;
    logic [IW-1:0]       l_idx;
    logic [IW-1:0]       rt_idx;
    logic [IW-1:0]       c_q;
    logic                full;
    logic                in_acc;
    logic                found;
    logic                parent_gt;
    logic                go_left;
    logic signed [31:0]  best;
    logic                go_right;
    logic signed [32:0]  add_sum;
    logic signed [31:0]  add_sat;
    logic [31:0]         fill32;
    logic                cfg_wr;

    // Effective capacity: zero means one, saturate at the slot count
    always_comb begin
        if (r_capacity == 11'd0) begin
            cap32 = 32'd1;
        end else if (32'(r_capacity) > 32'(CAPACITY)) begin
            cap32 = 32'(CAPACITY);
        end else begin
            cap32 = 32'(r_capacity);
        end
    end

    assign cap_i  = cap32[IW-1:0];
    assign fill_i = IW'(r_fill);
    assign last_i = fill_i - 1'b1;
    assign full   = fill_i >= cap_i;
    assign l_idx  = {r_t[IW-2:0], 1'b1};
    assign rt_idx = l_idx + 1'b1;
    assign c_q    = (r_p - 1'b1) >> 1;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign rdata  = t_entry'(rdata_raw);
    assign found  = r_sv && (rdata.id == r_id);
    assign parent_gt = rdata.score > r_sc;

    // Smallest of node, left and right; the node wins ties, then the left child
    assign go_left  = r_lc.score < r_v.score;
    assign best     = go_left ? r_lc.score : r_v.score;
    assign go_right = r_rv && (rdata.score < best);

    // Saturating add of the increment to the found score
    assign add_sum = 33'(rdata.score) + 33'(r_sc);
    always_comb begin
        if (add_sum > 33'(SCORE_MAX)) begin
            add_sat = SCORE_MAX;
        end else if (add_sum < 33'(SCORE_MIN)) begin
            add_sat = SCORE_MIN;
        end else begin
            add_sat = add_sum[31:0];
        end
    end

    // Drive the RAM ports from the current step
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_t[AW-1:0];
        wr_data = r_v;
        unique case (r_state)
            S_PU_RD: begin
                if (r_p == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_p[AW-1:0];
                    wr_data = '{id: r_id, score: r_sc};
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = c_q[AW-1:0];
                end
            end
            S_PU_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_p[AW-1:0];
                wr_data = parent_gt ? rdata : t_entry'{id: r_id, score: r_sc};
            end
            S_ROOT_RD, S_TH_RD: begin
                rd_en = 1'b1;
            end
            S_ROOT_GET: begin
                if (r_cmd == CMD_POP) begin
                    rd_en   = 1'b1;
                    rd_addr = last_i[AW-1:0];
                end
            end
            S_SRCH: begin
                if (found) begin
                    if (r_cmd == CMD_REMOVE) begin
                        rd_en   = 1'b1;
                        rd_addr = last_i[AW-1:0];
                    end
                end else if (r_si < fill_i) begin
                    rd_en   = 1'b1;
                    rd_addr = r_si[AW-1:0];
                end
            end
            S_SD_L: begin
                if (l_idx >= fill_i) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = l_idx[AW-1:0];
                end
            end
            S_SD_R: begin
                if (rt_idx < fill_i) begin
                    rd_en   = 1'b1;
                    rd_addr = rt_idx[AW-1:0];
                end
            end
            S_SD_CMP: begin
                wr_en = 1'b1;
                if (go_right) begin
                    wr_data = rdata;
                end else if (go_left) begin
                    wr_data = r_lc;
                end
            end
            default: begin
            end
        endcase
    end

    tkh_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (64'(wr_data)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rdata_raw)
    );

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[10:0];
        end
    end
    assign prdata = (paddr[2] == REG_CAPACITY) ? {21'd0, r_capacity} : 32'd0;
    assign pready = 1'b1;

    // Command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_thr    <= SCORE_MIN;
            r_ovalid <= 1'b0;
        end else begin
            // Raise the result flag as a command completes, drop it once taken
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= s_axis_tuser;
                        r_id   <= s_axis_tdata[31:0];
                        r_sc   <= s_axis_tdata[63:32];
                        r_dout <= NO_ID;
                        r_sout <= '0;
                        r_hit  <= 1'b0;
                        r_si   <= '0;
                        r_sv   <= 1'b0;
                        r_state <= S_DONE;
                        unique case (s_axis_tuser)
                            CMD_CLEAR: begin
                                r_fill <= '0;
                                r_thr  <= SCORE_MIN;
                            end
                            CMD_PUSH: begin
                                if (full) begin
                                    r_state <= S_ROOT_RD;
                                end else begin
                                    r_p     <= fill_i;
                                    r_fill  <= r_fill + 1'b1;
                                    r_state <= S_PU_RD;
                                end
                            end
                            CMD_POP: begin
                                if (r_fill != '0) begin
                                    r_state <= S_ROOT_RD;
                                end
                            end
                            CMD_SET, CMD_ADD, CMD_REMOVE: begin
                                r_state <= S_SRCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PU_RD: begin
                    if (r_p == '0) begin
                        r_state <= full ? S_TH_RD : S_DONE;
                    end else begin
                        r_q     <= c_q;
                        r_state <= S_PU_CMP;
                    end
                end
                S_PU_CMP: begin
                    if (parent_gt) begin
                        r_p     <= r_q;
                        r_state <= S_PU_RD;
                    end else begin
                        r_state <= full ? S_TH_RD : S_DONE;
                    end
                end
                S_ROOT_RD: begin
                    r_state <= S_ROOT_GET;
                end
                S_ROOT_GET: begin
                    r_dout <= rdata.id;
                    r_hit  <= 1'b1;
                    r_t    <= '0;
                    if (r_cmd == CMD_POP) begin
                        r_sout  <= rdata.score;
                        r_state <= S_POP_LAST;
                    end else begin
                        r_v     <= '{id: r_id, score: r_sc};
                        r_thn   <= 1'b1;
                        r_state <= S_SD_L;
                    end
                end
                S_POP_LAST: begin
                    r_v     <= rdata;
                    r_thn   <= 1'b0;
                    r_fill  <= r_fill - 1'b1;
                    r_state <= (last_i != '0) ? S_SD_L : S_DONE;
                end
                S_SRCH: begin
                    if (found) begin
                        r_hit <= 1'b1;
                        r_t   <= r_sp;
                        unique case (r_cmd)
                            CMD_SET: begin
                                r_thn   <= full;
                                r_v     <= '{id: rdata.id, score: r_sc};
                                r_state <= S_SD_L;
                            end
                            CMD_ADD: begin
                                r_thn   <= full;
                                r_v     <= '{id: rdata.id, score: add_sat};
                                r_state <= S_SD_L;
                            end
                            default: begin
                                r_thn   <= (r_sp == '0);
                                r_state <= S_RM_LAST;
                            end
                        endcase
                    end else if (r_si < fill_i) begin
                        r_sp <= r_si;
                        r_sv <= 1'b1;
                        r_si <= r_si + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RM_LAST: begin
                    r_v     <= rdata;
                    r_fill  <= r_fill - 1'b1;
                    r_state <= S_SD_L;
                end
                S_SD_L: begin
                    if (l_idx >= fill_i) begin
                        r_state <= r_thn ? S_TH_RD : S_DONE;
                    end else begin
                        r_state <= S_SD_R;
                    end
                end
                S_SD_R: begin
                    r_lc    <= rdata;
                    r_rv    <= rt_idx < fill_i;
                    r_state <= S_SD_CMP;
                end
                S_SD_CMP: begin
                    if (go_right) begin
                        r_t     <= rt_idx;
                        r_state <= S_SD_L;
                    end else if (go_left) begin
                        r_t     <= l_idx;
                        r_state <= S_SD_L;
                    end else begin
                        r_state <= r_thn ? S_TH_RD : S_DONE;
                    end
                end
                S_TH_RD: begin
                    r_state <= S_TH_GET;
                end
                S_TH_GET: begin
                    r_thr   <= rdata.score;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Load the result register when the previous transaction has left
    assign fill32 = 32'(r_fill);
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_o_doc   <= r_dout;
            r_o_score <= r_sout;
            r_o_hit   <= r_hit;
            r_o_count <= fill32[10:0];
            r_o_thr   <= r_thr;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_o_thr, r_o_count, r_o_score, r_o_doc};
    assign m_axis_tuser  = r_o_hit;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(CAPACITY))
        else $error("fill count beyond slot count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == CMD_CLEAR) |=> (r_fill == '0 && r_thr == SCORE_MIN))
        else $error("clear did not empty the heap");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to the same slot");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !m_axis_tready) |=> (r_state == S_DONE))
        else $error("result dropped while output busy");

endmodule

### rtl/tkh_ram.sv
module tkh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tkh_pkg::*;

    localparam int HEAP_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        t_cmd               cmd;
        logic        [31:0] doc_id;
        logic signed [31:0] score;
    } t_command;

    typedef struct packed {
        logic        [31:0] doc_out;
        logic signed [31:0] score_out;
        logic               hit;
        logic        [10:0] count;
        logic signed [31:0] threshold;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    topk_min_heap_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow heap
    logic        [31:0] shadow_ids[HEAP_DEPTH];
    logic signed [31:0] shadow_scores[HEAP_DEPTH];
    int                 shadow_fill;
    logic signed [31:0] shadow_threshold;
    logic        [10:0] shadow_capacity;

    t_command pending_cmds[$];
    t_outcome expected_outcomes[$];
    int       errors;
    int       cycles;
    int       outcomes_seen;
    int       burst_left;
    int       gap_left;
    int       stall_phase;

    always #10 i_clk = ~i_clk;

    function automatic int clamped_capacity();
        int c;
        c = shadow_capacity;
        if (c < 1) c = 1;
        if (c > HEAP_DEPTH) c = HEAP_DEPTH;
        return c;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic        [31:0] ti;
        logic signed [31:0] ts;
        ti = shadow_ids[a];
        ts = shadow_scores[a];
        shadow_ids[a] = shadow_ids[b];
        shadow_scores[a] = shadow_scores[b];
        shadow_ids[b] = ti;
        shadow_scores[b] = ts;
    endfunction

    function automatic void sink_entry(int t);
        int l, r, m;
        while (t < shadow_fill) begin
            l = 2 * t + 1;
            r = 2 * t + 2;
            m = t;
            if (l < shadow_fill && shadow_scores[l] < shadow_scores[m]) m = l;
            if (r < shadow_fill && shadow_scores[r] < shadow_scores[m]) m = r;
            if (m == t) break;
            swap_entries(t, m);
            t = m;
        end
    endfunction

    function automatic int locate_id(logic [31:0] id);
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_ids[i] == id) return i;
        return -1;
    endfunction

    // Apply one command to the shadow heap and return the outcome
    function automatic t_outcome heap_outcome(t_command c);
        t_outcome o;
        int cap, p, q, pos;
        longint s;
        cap = clamped_capacity();
        o.doc_out = NO_ID;
        o.score_out = '0;
        o.hit = 1'b0;
        case (c.cmd)
            CMD_CLEAR: begin
                shadow_fill = 0;
                shadow_threshold = SCORE_MIN;
            end
            CMD_PUSH: begin
                if (shadow_fill >= cap) begin
                    o.doc_out = shadow_ids[0];
                    o.hit = 1'b1;
                    shadow_ids[0] = c.doc_id;
                    shadow_scores[0] = c.score;
                    sink_entry(0);
                end else begin
                    p = shadow_fill;
                    shadow_fill++;
                    while (p > 0 && shadow_scores[(p - 1) / 2] > c.score) begin
                        q = (p - 1) / 2;
                        shadow_ids[p] = shadow_ids[q];
                        shadow_scores[p] = shadow_scores[q];
                        p = q;
                    end
                    shadow_ids[p] = c.doc_id;
                    shadow_scores[p] = c.score;
                end
                if (shadow_fill >= cap) shadow_threshold = shadow_scores[0];
            end
            CMD_POP: begin
                if (shadow_fill >= 1) begin
                    o.doc_out = shadow_ids[0];
                    o.score_out = shadow_scores[0];
                    o.hit = 1'b1;
                    shadow_fill--;
                    if (shadow_fill >= 1) begin
                        shadow_ids[0] = shadow_ids[shadow_fill];
                        shadow_scores[0] = shadow_scores[shadow_fill];
                        sink_entry(0);
                    end
                end
            end
            CMD_SET, CMD_ADD: begin
                pos = locate_id(c.doc_id);
                if (pos >= 0) begin
                    o.hit = 1'b1;
                    if (c.cmd == CMD_SET) begin
                        shadow_scores[pos] = c.score;
                    end else begin
                        s = longint'(shadow_scores[pos]) + longint'(c.score);
                        if (s > longint'(SCORE_MAX)) s = longint'(SCORE_MAX);
                        if (s < longint'(SCORE_MIN)) s = longint'(SCORE_MIN);
                        shadow_scores[pos] = s[31:0];
                    end
                    sink_entry(pos);
                    if (shadow_fill >= cap) shadow_threshold = shadow_scores[0];
                end
            end
            CMD_REMOVE: begin
                pos = locate_id(c.doc_id);
                if (pos >= 0) begin
                    o.hit = 1'b1;
                    shadow_ids[pos] = shadow_ids[shadow_fill - 1];
                    shadow_scores[pos] = shadow_scores[shadow_fill - 1];
                    shadow_fill--;
                    sink_entry(pos);
                    if (pos == 0) shadow_threshold = shadow_scores[0];
                end
            end
            default: ;
        endcase
        o.count = shadow_fill[10:0];
        o.threshold = shadow_threshold;
        return o;
    endfunction

    // Sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) expected_outcomes.insert(expected_outcomes.size(),
                heap_outcome(t_command'({s_axis_tuser, s_axis_tdata[31:0],
                                         s_axis_tdata[63:32]})));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_cmds[0].cmd;
                s_axis_tdata <= {pending_cmds[0].score, pending_cmds[0].doc_id};
                void'(pending_cmds.pop_front());
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_outcome(t_outcome e);
        t_outcome a;
        a.doc_out = m_axis_tdata[31:0];
        a.score_out = m_axis_tdata[63:32];
        a.count = m_axis_tdata[74:64];
        a.threshold = m_axis_tdata[106:75];
        a.hit = m_axis_tuser[0];
        if (a != e || m_axis_tdata[111:107] != '0) begin
            errors <= errors + 1;
            $display("%0t: doc expected %h actual %h, score expected %h actual %h",
                $time, e.doc_out, a.doc_out, e.score_out, a.score_out);
            $display("%0t: hit %b/%b count %0d/%0d threshold %h/%h pad %h", $time,
                e.hit, a.hit, e.count, a.count, e.threshold, a.threshold,
                m_axis_tdata[111:107]);
        end
    endtask

    // Receiver stall pattern and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 99) < 60 + stall_phase[3:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                outcomes_seen <= outcomes_seen + 1;
                if (expected_outcomes.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected transaction, actual %h/%b", $time,
                        m_axis_tdata, m_axis_tuser);
                end else begin
                    check_outcome(expected_outcomes.pop_front());
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("topk_min_heap_top: mismatch");
            $finish;
        end
    end

    task automatic queue_cmd(t_cmd c, logic [31:0] id, logic [31:0] sc);
        t_command t;
        t.cmd = c;
        t.doc_id = id;
        t.score = sc;
        pending_cmds.insert(pending_cmds.size(), t);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [10:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_CAPACITY);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_capacity = value;
    endtask

    // Mostly pushes and searches on a small id pool so hits are common
    task automatic random_phase(int n, int id_span);
        int k;
        logic [31:0] sc;
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) c = CMD_PUSH;
            else if (k < 55) c = CMD_POP;
            else if (k < 68) c = CMD_SET;
            else if (k < 81) c = CMD_ADD;
            else if (k < 94) c = CMD_REMOVE;
            else if (k < 96) c = CMD_CLEAR;
            else c = t_cmd'($urandom_range(6, 7));
            case ($urandom_range(0, 5))
                0: sc = $urandom;
                1: sc = $urandom_range(0, 1) ? SCORE_MAX - $urandom_range(0, 9) :
                                                SCORE_MIN + $urandom_range(0, 9);
                default: sc = 32'($urandom_range(0, 4000)) - 32'sd2000;
            endcase
            queue_cmd(c, ($urandom_range(0, 15) == 0) ? $urandom :
                         32'($urandom_range(0, id_span)), sc);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        outcomes_seen = 0;
        shadow_fill = 0;
        shadow_threshold = SCORE_MIN;
        shadow_capacity = CAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, extremes, every command, misses, overflow
        queue_cmd(CMD_POP, 32'h0, 32'h0);
        queue_cmd(CMD_REMOVE, 32'h5, 32'h0);
        queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, SCORE_MAX);
        queue_cmd(CMD_PUSH, 32'h0, SCORE_MIN);
        queue_cmd(CMD_PUSH, 32'h7, 32'h0001_0000);
        queue_cmd(CMD_PUSH, 32'h7, 32'h0000_8000);
        queue_cmd(CMD_ADD, 32'hFFFF_FFFF, SCORE_MAX);
        queue_cmd(CMD_ADD, 32'h0, SCORE_MIN);
        queue_cmd(CMD_SET, 32'h7, 32'hFFFF_0000);
        queue_cmd(CMD_SET, 32'h1234, 32'h0);
        queue_cmd(CMD_REMOVE, 32'h0, 32'h0);
        queue_cmd(t_cmd'(6), 32'h7, 32'h0);
        queue_cmd(t_cmd'(7), 32'hAAAA_5555, 32'h5555_AAAA);
        queue_cmd(CMD_POP, 32'h0, 32'h0);
        queue_cmd(CMD_CLEAR, 32'h0, 32'h0);
        drain();

        // Capacity two: full pushes evict the root; then lower below count
        write_capacity(11'd2);
        queue_cmd(CMD_PUSH, 32'h10, 32'sd5);
        queue_cmd(CMD_PUSH, 32'h11, 32'sd3);
        queue_cmd(CMD_PUSH, 32'h12, 32'sd9);
        queue_cmd(CMD_REMOVE, 32'h10, 32'h0);
        queue_cmd(CMD_PUSH, 32'h13, 32'sd1);
        queue_cmd(CMD_PUSH, 32'h14, 32'sd2);
        drain();
        write_capacity(11'd1);
        queue_cmd(CMD_PUSH, 32'h15, 32'sd4);
        queue_cmd(CMD_REMOVE, 32'h15, 32'h0);
        drain();

        // Zero and oversize capacity, then a spread of settings
        write_capacity(11'd0);
        random_phase(150, 7);
        drain();
        write_capacity(11'h7FF);
        random_phase(350, 300);
        drain();
        write_capacity(11'd5);
        random_phase(500, 15);
        drain();
        write_capacity(11'd1024);
        random_phase(200, 400);
        drain();
        write_capacity(11'd33);
        random_phase(750, 60);
        drain();

        $display("Covered %0d results over capacities 0, 1, 2, 5, 33, 1024 and 2047,",
            outcomes_seen);
        $display("with empty pops, misses, evictions, saturating adds and unknown commands.");
        if (errors == 0) begin
            $display("topk_min_heap_top: match");
        end else begin
            $display("topk_min_heap_top: mismatch");
        end
        $finish;
    end

endmodule
